FILE: sv/rmq_pkg.sv
// Shared constants for the rotation-matrix-to-quaternion pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
  localparam int RMQ_DATA_WIDTH = 16;
  // Index of the largest candidate sum, equal to the component it selects
  localparam logic [1:0] SEL_SCALAR = 2'd0;
  localparam logic [1:0] SEL_X      = 2'd1;
  localparam logic [1:0] SEL_Y      = 2'd2;
  localparam logic [1:0] SEL_Z      = 2'd3;
endpackage
`default_nettype wire

FILE: sv/rotation_matrix_to_quaternion_top.sv
// Pipelined rotation matrix to quaternion conversion (Shepperd's method).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | to block  | in_valid_i/in_stall_o | r00_i .. r22_i, signed Q2.14
//   out     | from block| out_valid_o/out_stall_i| q_scalar_o, q_x_o, q_y_o, q_z_o
//
// One beat enters per cycle unless the output stalls. Two stages
// form and select the sums, DATA_WIDTH stages resolve one square-root bit
// each, one stage sets up the divides, DATA_WIDTH+1 stages resolve one
// quotient bit each, and one stage saturates into the output register.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
#(
  parameter int DATA_WIDTH = RMQ_DATA_WIDTH
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire signed [DATA_WIDTH-1:0]  r00_i,
  input  wire signed [DATA_WIDTH-1:0]  r01_i,
  input  wire signed [DATA_WIDTH-1:0]  r02_i,
  input  wire signed [DATA_WIDTH-1:0]  r10_i,
  input  wire signed [DATA_WIDTH-1:0]  r11_i,
  input  wire signed [DATA_WIDTH-1:0]  r12_i,
  input  wire signed [DATA_WIDTH-1:0]  r20_i,
  input  wire signed [DATA_WIDTH-1:0]  r21_i,
  input  wire signed [DATA_WIDTH-1:0]  r22_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0] q_scalar_o,
  output logic signed [DATA_WIDTH-1:0] q_x_o,
  output logic signed [DATA_WIDTH-1:0] q_y_o,
  output logic signed [DATA_WIDTH-1:0] q_z_o
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = W - 2;
  localparam int SW = W + 3;        // candidate sums, signed
  localparam int MW = W + 1;        // positive chosen sum
  localparam int DW = W + 1;        // off-diagonal sums and differences, signed
  localparam int NW = 2 * W;        // dividend
  localparam int QB = W + 1;        // quotient bits
  localparam int NS = W + QB + 4;   // pipeline depth

  localparam logic signed [W-1:0] FMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] FMIN = {1'b1, {(W-1){1'b0}}};

  logic [NS-1:0] vld_q;
  logic          en;

  assign en          = !(vld_q[NS-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // ---------------- stage A: sums and differences
  logic signed [SW-1:0] m_q [4];
  logic signed [DW-1:0] e0_q, e1_q, e2_q, p01_q, p26_q, p57_q;
  logic signed [SW-1:0] a0, a4, a8, one;

  assign a0  = SW'(r00_i);
  assign a4  = SW'(r11_i);
  assign a8  = SW'(r22_i);
  assign one = SW'(1) << F;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0] <= one + a0 + a4 + a8;
      m_q[1] <= one + a0 - a4 - a8;
      m_q[2] <= one - a0 + a4 - a8;
      m_q[3] <= one - a0 - a4 + a8;
      e0_q   <= DW'(r12_i) - DW'(r21_i);
      e1_q   <= DW'(r20_i) - DW'(r02_i);
      e2_q   <= DW'(r01_i) - DW'(r10_i);
      p01_q  <= DW'(r01_i) + DW'(r10_i);
      p26_q  <= DW'(r02_i) + DW'(r20_i);
      p57_q  <= DW'(r12_i) + DW'(r21_i);
    end
  end

  // ---------------- stage B: pick the largest sum, route the numerators
  logic [1:0]           sel;
  logic signed [SW-1:0] mbest;
  logic signed [DW-1:0] dsel [4];

  always_comb begin
    sel   = SEL_SCALAR;
    mbest = m_q[0];
    if (m_q[1] > mbest) begin
      sel   = SEL_X;
      mbest = m_q[1];
    end
    if (m_q[2] > mbest) begin
      sel   = SEL_Y;
      mbest = m_q[2];
    end
    if (m_q[3] > mbest) begin
      sel   = SEL_Z;
      mbest = m_q[3];
    end
    for (int k = 0; k < 4; k++) dsel[k] = '0;
    case (sel)
      SEL_SCALAR: begin
        dsel[1] = e0_q;  dsel[2] = e1_q;  dsel[3] = e2_q;
      end
      SEL_X: begin
        dsel[0] = e0_q;  dsel[2] = p01_q; dsel[3] = p26_q;
      end
      SEL_Y: begin
        dsel[0] = e1_q;  dsel[1] = p01_q; dsel[3] = p57_q;
      end
      SEL_Z: begin
        dsel[0] = e2_q;  dsel[1] = p26_q; dsel[2] = p57_q;
      end
      default: begin
        dsel[0] = e0_q;
      end
    endcase
  end

  logic          bz_q;
  logic [1:0]    bsel_q;
  logic [MW-1:0] bm_q;
  logic signed [DW-1:0] bd_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      bz_q   <= (mbest <= 0);
      bsel_q <= sel;
      bm_q   <= mbest[MW-1:0];
      for (int k = 0; k < 4; k++) bd_q[k] <= dsel[k];
    end
  end

  // ---------------- square root, one result bit per stage
  logic [W+1:0] sr_q [W];
  logic [W-1:0] st_q [W];
  logic [MW-1:0] sm_q [W];
  logic          sz_q [W];
  logic [1:0]    ss_q [W];
  logic signed [DW-1:0] sd_q [W][4];

  for (genvar j = 0; j < W; j++) begin : g_sqrt
    logic [W+1:0]  rem_in, rem_sh, trial;
    logic [W-1:0]  root_in;
    logic [MW-1:0] m_in;
    logic [NW-1:0] v;
    logic          z_in;
    logic [1:0]    s_in;
    logic signed [DW-1:0] d_in [4];

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign m_in    = bm_q;
      assign z_in    = bz_q;
      assign s_in    = bsel_q;
      assign d_in    = bd_q;
    end else begin : g_next
      assign rem_in  = sr_q[j-1];
      assign root_in = st_q[j-1];
      assign m_in    = sm_q[j-1];
      assign z_in    = sz_q[j-1];
      assign s_in    = ss_q[j-1];
      assign d_in    = sd_q[j-1];
    end

    assign v      = {1'b0, m_in, {F{1'b0}}};
    assign rem_sh = {rem_in[W-1:0], v[NW-1-2*j -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rem_sh >= trial) begin
          sr_q[j] <= rem_sh - trial;
          st_q[j] <= {root_in[W-2:0], 1'b1};
        end else begin
          sr_q[j] <= rem_sh;
          st_q[j] <= {root_in[W-2:0], 1'b0};
        end
        sm_q[j] <= m_in;
        sz_q[j] <= z_in;
        ss_q[j] <= s_in;
        sd_q[j] <= d_in;
      end
    end
  end

  // ---------------- divide setup
  logic [W-1:0]  root;
  logic [W:0]    dvs;
  logic [NW-1:0] num [4];
  logic [DW-1:0] ad  [4];

  assign root = st_q[W-1];
  assign dvs  = {root, 1'b0};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ad[k]  = sd_q[W-1][k][DW-1] ? DW'(-sd_q[W-1][k]) : DW'(sd_q[W-1][k]);
      num[k] = NW'({ad[k], {F{1'b0}}}) + NW'(root);
    end
  end

  logic [NW-1:0] dr_q [QB+1][4];
  logic [QB-1:0] dq_q [QB+1][4];
  logic [W:0]    dv_q [QB+1];
  logic [3:0]    dsg_q [QB+1];
  logic [3:0]    dov_q [QB+1];
  logic [W-1:0]  dh_q [QB+1];
  logic          dz_q [QB+1];
  logic [1:0]    ds_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        dr_q[0][k]   <= num[k];
        dq_q[0][k]   <= '0;
        dsg_q[0][k]  <= sd_q[W-1][k][DW-1];
        dov_q[0][k]  <= ({2'b00, num[k][NW-1:QB]} >= dvs);
      end
      dv_q[0] <= dvs;
      dh_q[0] <= W'((MW'(root) + MW'(1)) >> 1);
      dz_q[0] <= sz_q[W-1];
      ds_q[0] <= ss_q[W-1];
    end
  end

  // ---------------- restoring divide, one quotient bit per stage
  for (genvar t = 0; t < QB; t++) begin : g_div
    localparam int KB = QB - 1 - t;
    logic [NW:0] sh;

    assign sh = (NW + 1)'(dv_q[t]) << KB;

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 4; k++) begin
          if ({1'b0, dr_q[t][k]} >= sh) begin
            dr_q[t+1][k] <= dr_q[t][k] - sh[NW-1:0];
            dq_q[t+1][k] <= {dq_q[t][k][QB-2:0], 1'b1};
          end else begin
            dr_q[t+1][k] <= dr_q[t][k];
            dq_q[t+1][k] <= {dq_q[t][k][QB-2:0], 1'b0};
          end
        end
        dv_q[t+1]  <= dv_q[t];
        dsg_q[t+1] <= dsg_q[t];
        dov_q[t+1] <= dov_q[t];
        dh_q[t+1]  <= dh_q[t];
        dz_q[t+1]  <= dz_q[t];
        ds_q[t+1]  <= ds_q[t];
      end
    end
  end

  // ---------------- sign fix and saturation
  logic [QB-1:0]       mag [4];
  logic                neg [4];
  logic                flip;
  logic signed [W-1:0] res [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (ds_q[QB] == 2'(k)) begin
        mag[k] = QB'(dh_q[QB]);
      end else if (dov_q[QB][k]) begin
        mag[k] = '1;
      end else begin
        mag[k] = dq_q[QB][k];
      end
    end
    // negate everything when the scalar part came out negative
    flip = (ds_q[QB] != SEL_SCALAR) && dsg_q[QB][0] && (mag[0] != '0);
    for (int k = 0; k < 4; k++) begin
      neg[k] = ((ds_q[QB] == 2'(k)) ? 1'b0 : dsg_q[QB][k]) ^ flip;
      if (dz_q[QB]) begin
        res[k] = '0;
      end else if (neg[k]) begin
        if (mag[k] >= QB'(FMIN[W-1:0])) res[k] = FMIN;
        else                            res[k] = -$signed(mag[k][W-1:0]);
      end else begin
        if (mag[k] > QB'(FMAX)) res[k] = FMAX;
        else                    res[k] = $signed(mag[k][W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_scalar_o <= res[0];
      q_x_o      <= res[1];
      q_y_o      <= res[2];
      q_z_o      <= res[3];
    end
  end

  // ---------------- checks
  a_scalar_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !q_scalar_o[W-1])
    else $error("negative scalar part on output");

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with free output");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (vld_q[1] == $past(vld_q[0])))
    else $error("valid bit lost in pipeline");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved under stall");
endmodule
`default_nettype wire
